// ===== rtl/sstq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
// No dependencies.
package sstq_pkg;
    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W = 5;
    localparam int TS_W = 6;
    localparam logic [TS_W-1:0] TASK_NONE = 6'd32;

    typedef enum logic [2:0] {
        F_ALLOC = 3'd0, F_FREE = 3'd1, F_INIT = 3'd2, F_SETTIME = 3'd3,
        F_CANCEL = 3'd4, F_CANCEL_ALL = 3'd5, F_TICK = 3'd6, F_NONE = 3'd7
    } func_t;

    localparam logic [1:0] K_DONE = 2'd0;
    localparam logic [1:0] K_EXPIRY = 2'd1;
    localparam logic [1:0] K_TICK = 2'd2;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN = 2'd2;

    typedef struct packed {
        func_t       func;
        logic [4:0]  slot_id;
        logic [31:0] delay;
        logic [7:0]  queue_id;
        logic [31:0] event_value;
        logic        auto_cancel;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [4:0]  slot_out;
        logic [7:0]  queue_out;
        logic [31:0] value_out;
        logic        switch_req;
        logic        last;
    } res_t;
endpackage

// ===== rtl/sstq_cmd_fifo.sv =====
// Short command queue between the front end and the engine.
// Depends on sstq_pkg.
module sstq_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sstq_pkg::cmd_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output sstq_pkg::cmd_t rdata
);
    import sstq_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ (push && !full);
        rp_next  = rp_reg ^ (pop && !empty);
        cnt_next = cnt_reg + 2'(push && !full) - 2'(pop && !empty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= wdata;
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("fifo count overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("fifo pointers inconsistent");
    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !(pop && !empty)) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("fifo count did not grow");
`endif
endmodule

// ===== rtl/sstq_engine.sv =====
// Timer engine: slot tables, sorted list walk, result generation.
// Depends on sstq_pkg.
module sstq_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sstq_pkg::TS_W-1:0] task_slot,
    input  logic                      cmd_valid,
    input  sstq_pkg::cmd_t            cmd,
    output logic                      cmd_pop,
    output logic                      res_valid,
    output sstq_pkg::res_t            res,
    input  logic                      res_take
);
    import sstq_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001, S_SCAN  = 7'b0000010, S_REM = 7'b0000100,
        S_INS   = 7'b0001000, S_SHIFT = 7'b0010000, S_TICK = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t          state_reg;
    logic [1:0]      status_reg [NUM_SLOTS];
    logic            ac_reg [NUM_SLOTS];
    logic [31:0]     dl_mem [NUM_SLOTS];
    logic [7:0]      q_mem [NUM_SLOTS];
    logic [31:0]     v_mem [NUM_SLOTS];
    logic [IW-1:0]   ord_reg [NUM_SLOTS];
    logic [CW-1:0]   rc_reg;
    logic [31:0]     tick_reg;
    cmd_t            c_reg;
    logic [CW-1:0]   p_reg;
    logic            ts_reg;
    logic            kill_reg;
    logic            out_reg;
    res_t            res_reg;
    logic            ins_reg;
    logic [31:0]     nd_reg;
    logic [31:0]     pd_reg;
    logic [IW-1:0]   cs;
    logic            sv;
    logic [IW-1:0]   head;
    logic [IW-1:0]   pidx;
    logic [31:0]     tick_inc;

    assign cs       = IW'(c_reg.slot_id);
    assign sv       = 32'(c_reg.slot_id) < NUM_SLOTS;
    assign head     = ord_reg[0];
    assign pidx     = p_reg[IW-1:0];
    assign tick_inc = tick_reg + 32'd1;
    assign res_valid = out_reg;
    assign res       = res_reg;
    assign cmd_pop   = state_reg == S_IDLE && cmd_valid && !out_reg;

    always_ff @(posedge clk)
    begin
        pd_reg <= dl_mem[ord_reg[pidx]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rc_reg    <= '0;
            tick_reg  <= '0;
            out_reg   <= 1'b0;
            p_reg     <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status_reg[i] <= ST_FREE;
                ac_reg[i]     <= 1'b0;
            end
        end
        else
        begin
            if (out_reg && res_take)
                out_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        c_reg    <= cmd;
                        ts_reg   <= 1'b0;
                        p_reg    <= '0;
                        res_reg  <= '{K_DONE, 1'b0, 5'd0, 8'd0, 32'd0, 1'b0, 1'b1};
                        unique case (cmd.func)
                            F_TICK:
                            begin
                                tick_reg  <= tick_inc;
                                state_reg <= S_TICK;
                            end
                            F_CANCEL_ALL, F_ALLOC: state_reg <= S_SCAN;
                            default: state_reg <= S_SCAN;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    priority case (c_reg.func)
                        F_ALLOC:
                        begin
                            if (status_reg[pidx] == ST_FREE)
                            begin
                                status_reg[pidx] <= ST_ALLOC;
                                ac_reg[pidx]     <= 1'b0;
                                res_reg.ok       <= 1'b1;
                                res_reg.slot_out <= 5'(pidx);
                                out_reg          <= 1'b1;
                                state_reg        <= S_IDLE;
                            end
                            else if (p_reg == CW'(NUM_SLOTS - 1))
                            begin
                                out_reg   <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                                p_reg <= p_reg + 1'b1;
                        end
                        F_CANCEL_ALL:
                        begin
                            if (status_reg[pidx] != ST_FREE && ac_reg[pidx]
                                && q_mem[pidx] == c_reg.queue_id)
                            begin
                                c_reg.slot_id <= 5'(pidx);
                                kill_reg      <= 1'b1;
                                ins_reg       <= 1'b0;
                                status_reg[pidx] <= ST_FREE;
                                if (status_reg[pidx] == ST_RUN)
                                begin
                                    nd_reg    <= {27'd0, 5'(pidx)};
                                    state_reg <= S_REM;
                                    p_reg     <= '0;
                                end
                                else if (p_reg == CW'(NUM_SLOTS - 1))
                                begin
                                    out_reg   <= 1'b1;
                                    state_reg <= S_IDLE;
                                end
                                else
                                    p_reg <= p_reg + 1'b1;
                            end
                            else if (p_reg == CW'(NUM_SLOTS - 1))
                            begin
                                out_reg   <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                                p_reg <= p_reg + 1'b1;
                        end
                        default:
                        begin
                            ins_reg  <= 1'b0;
                            kill_reg <= 1'b0;
                            if (!sv || c_reg.func == F_NONE)
                            begin
                                out_reg   <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else if (c_reg.func == F_INIT)
                            begin
                                q_mem[cs]  <= c_reg.queue_id;
                                v_mem[cs]  <= c_reg.event_value;
                                ac_reg[cs] <= c_reg.auto_cancel;
                                out_reg    <= 1'b1;
                                state_reg  <= S_IDLE;
                            end
                            else if (c_reg.func == F_SETTIME && status_reg[cs] == ST_FREE)
                            begin
                                out_reg   <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                if (c_reg.func == F_SETTIME)
                                begin
                                    ins_reg     <= 1'b1;
                                    dl_mem[cs]  <= c_reg.delay + tick_reg;
                                    nd_reg      <= c_reg.delay + tick_reg;
                                    status_reg[cs] <= ST_RUN;
                                end
                                else if (c_reg.func == F_FREE)
                                    status_reg[cs] <= ST_FREE;
                                else if (status_reg[cs] == ST_RUN)
                                begin
                                    status_reg[cs] <= ST_ALLOC;
                                    res_reg.ok     <= 1'b1;
                                end
                                if (status_reg[cs] == ST_RUN)
                                    state_reg <= S_REM;
                                else if (c_reg.func == F_SETTIME)
                                    state_reg <= S_INS;
                                else
                                begin
                                    out_reg   <= 1'b1;
                                    state_reg <= S_IDLE;
                                end
                                p_reg <= '0;
                            end
                        end
                    endcase
                end
                S_REM:
                begin
                    // find slot in list, then close the gap
                    if (p_reg >= rc_reg)
                        state_reg <= S_IDLE;
                    else if (ord_reg[pidx] == cs)
                    begin
                        for (int i = 0; i < NUM_SLOTS - 1; i++)
                            if (CW'(i) >= p_reg)
                                ord_reg[i] <= ord_reg[i + 1];
                        rc_reg <= rc_reg - 1'b1;
                        if (ins_reg)
                        begin
                            p_reg     <= '0;
                            state_reg <= S_INS;
                        end
                        else if (kill_reg)
                        begin
                            p_reg     <= CW'(nd_reg[IW-1:0]) + 1'b1;
                            state_reg <= (nd_reg[IW-1:0] == IW'(NUM_SLOTS - 1))
                                         ? S_OUT : S_SCAN;
                            c_reg.slot_id <= 5'(nd_reg[IW-1:0]);
                        end
                        else
                        begin
                            p_reg     <= '0;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                        p_reg <= p_reg + 1'b1;
                end
                S_INS:
                begin
                    // pd_reg is registered from p_reg: compare in S_SHIFT
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (p_reg < rc_reg && nd_reg > pd_reg)
                    begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= S_INS;
                    end
                    else
                    begin
                        for (int i = 1; i < NUM_SLOTS; i++)
                            if (CW'(i) > p_reg && CW'(i) <= rc_reg)
                                ord_reg[i] <= ord_reg[i - 1];
                        ord_reg[pidx] <= cs;
                        rc_reg        <= rc_reg + 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_TICK:
                begin
                    if (!out_reg)
                    begin
                        if (rc_reg != '0 && dl_mem[head] <= tick_reg)
                        begin
                            for (int i = 0; i < NUM_SLOTS - 1; i++)
                                ord_reg[i] <= ord_reg[i + 1];
                            rc_reg           <= rc_reg - 1'b1;
                            status_reg[head] <= ST_ALLOC;
                            if (TS_W'(head) == task_slot)
                                ts_reg <= 1'b1;
                            else
                            begin
                                res_reg.kind      <= K_EXPIRY;
                                res_reg.ok        <= 1'b0;
                                res_reg.slot_out  <= 5'(head);
                                res_reg.queue_out <= q_mem[head];
                                res_reg.value_out <= v_mem[head];
                                res_reg.switch_req <= 1'b0;
                                res_reg.last      <= 1'b0;
                                out_reg           <= 1'b1;
                            end
                        end
                        else
                        begin
                            res_reg   <= '{K_TICK, 1'b0, 5'd0, 8'd0, 32'd0, ts_reg, 1'b1};
                            out_reg   <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT:
                begin
                    out_reg   <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_rc: assert property (@(posedge clk) disable iff (!rst_n) rc_reg <= CW'(NUM_SLOTS))
        else $error("running count out of range");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> state_reg != S_IDLE)
        else $error("command accepted but engine idle");
`endif
endmodule

// ===== rtl/sorted_software_timer_queue_top.sv =====
// Sorted software timer queue, top level.
// Commands enter through a push/full port and are held in a two-entry
// command queue; the engine pops them one at a time and works on them.
// Results leave through an empty/pop port from a single output register;
// a command gives one result, a tick one result per expired timer except
// the task slot's, plus a final tick-finished result (last=1 marks the
// final one of each command). Alloc scans the slots, one per cycle; a
// removal walks the sorted list, one entry per cycle, and an insertion
// walks it through S_INS and S_SHIFT for each entry. cancel_all scans all
// slots and walks the list once per running timer it stops. In a tick,
// each expiry waits while its result is not popped.
// When pop stays low, the engine holds its result and stops; the
// command queue keeps taking up to two transactions.
// Reset clears all slots to free, the list, the tick count and the task
// slot register (to none).
// Depends on sstq_pkg, sstq_cmd_fifo, sstq_engine.
module sorted_software_timer_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  func,
    input  logic [4:0]  slot_id,
    input  logic [31:0] delay,
    input  logic [7:0]  queue_id,
    input  logic [31:0] event_value,
    input  logic        auto_cancel,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic        ok,
    output logic [4:0]  slot_out,
    output logic [7:0]  queue_out,
    output logic [31:0] value_out,
    output logic        switch_req,
    output logic        last
);
    import sstq_pkg::*;

    logic [TS_W-1:0] task_reg;
    cmd_t            wcmd, rcmd;
    logic            f_empty, f_pop, rv;
    res_t            r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            task_reg <= TASK_NONE;
        else if (cfg_we)
            task_reg <= cfg_wdata;
    end

    always_comb
    begin
        wcmd.func        = func_t'(func);
        wcmd.slot_id     = slot_id;
        wcmd.delay       = delay;
        wcmd.queue_id    = queue_id;
        wcmd.event_value = event_value;
        wcmd.auto_cancel = auto_cancel;
    end

    sstq_cmd_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(wcmd), .full(full),
        .pop(f_pop), .empty(f_empty), .rdata(rcmd)
    );

    sstq_engine u_eng (
        .clk(clk), .rst_n(rst_n), .task_slot(task_reg),
        .cmd_valid(!f_empty), .cmd(rcmd), .cmd_pop(f_pop),
        .res_valid(rv), .res(r), .res_take(pop)
    );

    assign empty       = !rv;
    assign kind        = r.kind;
    assign ok          = r.ok;
    assign slot_out    = r.slot_out;
    assign queue_out   = r.queue_out;
    assign value_out   = r.value_out;
    assign switch_req  = r.switch_req;
    assign last        = r.last;
endmodule

// ===== dv/sorted_software_timer_queue_top_tb.sv =====
// Testbench for sorted_software_timer_queue_top: directed table, then random commands
// over several task-slot settings, each result checked against an in-bench timer model.
// Depends on sstq_pkg and the sorted_software_timer_queue_top RTL.
module sorted_software_timer_queue_top_tb;
    import sstq_pkg::*;

    localparam int SLOTS = 32;
    localparam int QUIET = 3 * SLOTS + 40;
    localparam int WDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        cmd_t       c;
        bit         chk;
        bit         eok;
        logic [4:0] eslot;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [5:0]  cfg_wdata;
    logic        push;
    logic        full;
    logic [2:0]  func;
    logic [4:0]  slot_id;
    logic [31:0] delay;
    logic [7:0]  queue_id;
    logic [31:0] event_value;
    logic        auto_cancel;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic        ok;
    logic [4:0]  slot_out;
    logic [7:0]  queue_out;
    logic [31:0] value_out;
    logic        switch_req;
    logic        last;

    sorted_software_timer_queue_top uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .push(push), .full(full), .func(func), .slot_id(slot_id), .delay(delay),
        .queue_id(queue_id), .event_value(event_value), .auto_cancel(auto_cancel),
        .empty(empty), .pop(pop), .kind(kind), .ok(ok), .slot_out(slot_out),
        .queue_out(queue_out), .value_out(value_out), .switch_req(switch_req),
        .last(last)
    );

    // timer model state
    logic [1:0]  tm_status [SLOTS];
    logic [31:0] tm_deadline [SLOTS];
    logic [7:0]  tm_queue [SLOTS];
    logic [31:0] tm_value [SLOTS];
    bit          tm_ac [SLOTS];
    bit          tm_written [SLOTS];
    int          run_order [$];
    logic [31:0] tick_cnt;
    logic [5:0]  task_sel;

    res_t expected_res [$];
    int   errors;
    int   pops_seen;
    int   idle_cycles;
    bit   hold_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void list_drop(int s);
        foreach (run_order[p])
        begin
            if (run_order[p] == s)
            begin
                run_order.delete(p);
                return;
            end
        end
    endfunction

    function automatic void list_add(int s);
        int p;
        p = 0;
        while (p < run_order.size() && tm_deadline[s] > tm_deadline[run_order[p]])
            p++;
        run_order.insert(p, s);
    endfunction

    function automatic bit stop_timer(int s);
        if (tm_status[s] != ST_RUN)
            return 1'b0;
        list_drop(s);
        tm_status[s] = ST_ALLOC;
        return 1'b1;
    endfunction

    function automatic res_t timer_predict(cmd_t c);
        res_t r;
        int s;
        bit ts;
        s = int'(c.slot_id);
        ts = 1'b0;
        r = '0;
        r.kind = K_DONE;
        r.last = 1'b1;
        case (c.func)
            F_TICK:
            begin
                tick_cnt = tick_cnt + 1;
                while (run_order.size() > 0 && tm_deadline[run_order[0]] <= tick_cnt)
                begin
                    int e;
                    res_t x;
                    e = run_order.pop_front();
                    tm_status[e] = ST_ALLOC;
                    if (e == task_sel)
                        ts = 1'b1;
                    else
                    begin
                        x = '0;
                        x.kind = K_EXPIRY;
                        x.slot_out = 5'(e);
                        x.queue_out = tm_queue[e];
                        x.value_out = tm_value[e];
                        expected_res.push_back(x);
                    end
                end
                r.kind = K_TICK;
                r.switch_req = ts;
                expected_res.push_back(r);
                return r;
            end
            F_ALLOC:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tm_status[i] == ST_FREE)
                    begin
                        tm_status[i] = ST_ALLOC;
                        tm_ac[i] = 1'b0;
                        r.ok = 1'b1;
                        r.slot_out = 5'(i);
                        break;
                    end
                end
            end
            F_FREE:
            begin
                void'(stop_timer(s));
                tm_status[s] = ST_FREE;
            end
            F_INIT:
            begin
                tm_queue[s] = c.queue_id;
                tm_value[s] = c.event_value;
                tm_ac[s] = c.auto_cancel;
                tm_written[s] = 1'b1;
            end
            F_SETTIME:
            begin
                if (tm_status[s] != ST_FREE)
                begin
                    void'(stop_timer(s));
                    tm_deadline[s] = c.delay + tick_cnt;
                    tm_status[s] = ST_RUN;
                    list_add(s);
                end
            end
            F_CANCEL: r.ok = stop_timer(s);
            F_CANCEL_ALL:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tm_status[i] != ST_FREE && tm_ac[i] && tm_queue[i] == c.queue_id)
                    begin
                        void'(stop_timer(i));
                        tm_status[i] = ST_FREE;
                    end
                end
            end
            default: ;
        endcase
        expected_res.push_back(r);
        return r;
    endfunction

    function automatic row_t mk(func_t f, int s, logic [31:0] d, logic [7:0] q,
                                logic [31:0] v, bit ac, bit chk, bit eok, int esl);
        row_t w;
        w.c.func = f;
        w.c.slot_id = 5'(s);
        w.c.delay = d;
        w.c.queue_id = q;
        w.c.event_value = v;
        w.c.auto_cancel = ac;
        w.chk = chk;
        w.eok = eok;
        w.eslot = 5'(esl);
        return w;
    endfunction

    task automatic send_cmd(cmd_t c, output res_t r);
        func = c.func;
        slot_id = c.slot_id;
        delay = c.delay;
        queue_id = c.queue_id;
        event_value = c.event_value;
        auto_cancel = c.auto_cancel;
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
        r = timer_predict(c);
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic settle_and_config(logic [5:0] v);
        while (expected_res.size() > 0)
            @(negedge clk);
        repeat (QUIET) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        task_sel = v;
    endtask

    function automatic int pick_slot();
        int cand [$];
        for (int i = 0; i < SLOTS; i++)
            if (tm_status[i] != ST_FREE)
                cand.push_back(i);
        if (cand.size() > 0 && $urandom_range(0, 9) < 7)
            return cand[$urandom_range(0, cand.size() - 1)];
        return $urandom_range(0, SLOTS - 1);
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int r;
        c.slot_id = 5'(pick_slot());
        c.delay = $urandom;
        c.queue_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        c.event_value = $urandom;
        c.auto_cancel = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 20)
            c.func = F_ALLOC;
        else if (r < 25)
            c.func = F_FREE;
        else if (r < 38)
            c.func = F_INIT;
        else if (r < 58)
            c.func = F_SETTIME;
        else if (r < 65)
            c.func = F_CANCEL;
        else if (r < 69)
            c.func = F_CANCEL_ALL;
        else if (r < 97)
            c.func = F_TICK;
        else
            c.func = F_NONE;
        if (c.func == F_SETTIME)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                c.delay = $urandom_range(0, 6);
            else if (r < 8)
                c.delay = $urandom_range(0, 40);
            else if (r == 8)
                c.delay = $urandom_range(0, 1) ? 32'hffffffff : 32'hfffffff0;
            // arming a slot whose event was never set up is not allowed
            if (!tm_written[c.slot_id])
                c.func = F_INIT;
        end
        return c;
    endfunction

    // receiver
    initial
    begin
        int mode;
        int cnt;
        pop = 1'b0;
        mode = 0;
        cnt = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && pops_seen >= 80)
            begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (++cnt == 40)
            begin
                cnt = 0;
                mode = $urandom_range(0, 2);
            end
            case (mode)
                0: pop = 1'b1;
                1: pop = $urandom_range(0, 1);
                default: pop = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        bit   act;
        if (rst_n)
        begin
            act = (push && !full) || (pop && !empty);
            idle_cycles <= act ? 0 : idle_cycles + 1;
            if (pop && !empty)
            begin
                pops_seen <= pops_seen + 1;
                got.kind = kind;
                got.ok = ok;
                got.slot_out = slot_out;
                got.queue_out = queue_out;
                got.value_out = value_out;
                got.switch_req = switch_req;
                got.last = last;
                if (expected_res.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected transaction: kind=%0d slot=%0d", kind, slot_out);
                end
                else
                begin
                    want = expected_res.pop_front();
                    if (got.kind !== want.kind || got.ok !== want.ok
                        || got.slot_out !== want.slot_out || got.queue_out !== want.queue_out
                        || got.value_out !== want.value_out
                        || got.switch_req !== want.switch_req || got.last !== want.last)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                        begin
                            $display("mismatch: exp k=%0d ok=%0d s=%0d q=%h v=%h sw=%0d l=%0d",
                                     want.kind, want.ok, want.slot_out, want.queue_out,
                                     want.value_out, want.switch_req, want.last);
                            $display("          got k=%0d ok=%0d s=%0d q=%h v=%h sw=%0d l=%0d",
                                     got.kind, got.ok, got.slot_out, got.queue_out,
                                     got.value_out, got.switch_req, got.last);
                        end
                    end
                end
            end
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("sorted_software_timer_queue_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        row_t dir [$];
        res_t r;
        int burst;
        logic [5:0] cfg_vals [4];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        push = 1'b0;
        func = F_NONE;
        slot_id = '0;
        delay = '0;
        queue_id = '0;
        event_value = '0;
        auto_cancel = 1'b0;
        errors = 0;
        pops_seen = 0;
        idle_cycles = 0;
        tick_cnt = '0;
        task_sel = TASK_NONE;
        for (int i = 0; i < SLOTS; i++)
        begin
            tm_status[i] = ST_FREE;
            tm_deadline[i] = '0;
            tm_queue[i] = '0;
            tm_value[i] = '0;
            tm_ac[i] = 1'b0;
            tm_written[i] = 1'b0;
        end

        dir.push_back(mk(F_ALLOC, 0, 0, 0, 0, 0, 1, 1, 0));
        dir.push_back(mk(F_ALLOC, 0, 0, 0, 0, 0, 1, 1, 1));
        dir.push_back(mk(F_ALLOC, 31, 0, 0, 0, 0, 1, 1, 2));
        dir.push_back(mk(F_INIT, 0, 0, 8'hff, 32'hffffffff, 1, 1, 0, 0));
        dir.push_back(mk(F_INIT, 1, 0, 8'h00, 32'h0, 0, 1, 0, 0));
        dir.push_back(mk(F_INIT, 2, 0, 8'hff, 32'h12345678, 1, 1, 0, 0));
        dir.push_back(mk(F_SETTIME, 0, 32'h0, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_SETTIME, 1, 32'hffffffff, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_SETTIME, 2, 32'h1, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_SETTIME, 2, 32'h1, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(F_CANCEL, 1, 0, 0, 0, 0, 1, 1, 0));
        dir.push_back(mk(F_CANCEL, 1, 0, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_SETTIME, 5, 32'h0, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_FREE, 1, 0, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_NONE, 31, 32'hffffffff, 8'hff, 32'hffffffff, 1, 1, 0, 0));
        dir.push_back(mk(F_SETTIME, 0, 32'h3, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_SETTIME, 2, 32'h3, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_CANCEL_ALL, 0, 0, 8'hff, 0, 0, 1, 0, 0));
        dir.push_back(mk(F_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(F_ALLOC, 0, 0, 0, 0, 0, 1, 1, 0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        settle_and_config(TASK_NONE);
        foreach (dir[i])
        begin
            send_cmd(dir[i].c, r);
            if (dir[i].chk && (r.kind !== K_DONE || r.ok !== dir[i].eok
                || (dir[i].eok && r.slot_out !== dir[i].eslot)))
            begin
                errors++;
                $display("directed row %0d: exp ok=%0d slot=%0d, model ok=%0d slot=%0d",
                         i, dir[i].eok, dir[i].eslot, r.ok, r.slot_out);
            end
        end

        cfg_vals[0] = 6'd0;
        cfg_vals[1] = 6'd31;
        cfg_vals[2] = 6'd63;
        cfg_vals[3] = 6'($urandom_range(0, 32));
        burst = 0;
        foreach (cfg_vals[ph])
        begin
            settle_and_config(cfg_vals[ph]);
            for (int k = 0; k < 55; k++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 12);
                    repeat ($urandom_range(0, 15)) @(negedge clk);
                end
                burst--;
                send_cmd(rand_cmd(), r);
            end
        end

        while (expected_res.size() > 0)
            @(negedge clk);
        repeat (QUIET) @(negedge clk);
        if (errors == 0 && expected_res.size() == 0)
            $display("sorted_software_timer_queue_top_tb OK");
        else
            $display("sorted_software_timer_queue_top_tb NOT OK");
        $finish;
    end
endmodule
